// ===== rtl/nltp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nltp_pkg - shared types and constants for the number-list text parser
// Transfer payloads, token and accumulator state, and the number phase codes.
// ----------------------------------------------------------------------------
package nltp_pkg;

    // Width of the membership mask (values 1..MASK_BITS are members)
    localparam int MASK_BITS  = 32;
    localparam int MASK_IDX_W = $clog2(MASK_BITS);

    // Magnitude accumulator and saturation limit
    localparam int                NUM_W   = 31;
    localparam logic [NUM_W-1:0]  NUM_SAT = {NUM_W{1'b1}};

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Range bound value meaning "no range"
    localparam logic signed [31:0] NO_RANGE = -32'sd1;

    // Progress of the atoi-style number reader
    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        member_mask;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic               parse_error;
    } t_out_item;

    // Per-token reader state
    typedef struct packed {
        logic [NUM_W-1:0]   num_acc;
        logic signed [31:0] first_val;
        t_phase             phase;
        logic               neg;
        logic               in_second;
        logic               prev_dot;
    } t_tok_state;

    // Whole-text accumulators
    typedef struct packed {
        logic [MASK_BITS-1:0] mask;
        logic signed [31:0]   low;
        logic signed [31:0]   high;
        logic                 err;
    } t_acc_state;

    localparam t_tok_state TOK_RESET = '{
        num_acc:   '0,
        first_val: '0,
        phase:     PH_SKIP,
        neg:       1'b0,
        in_second: 1'b0,
        prev_dot:  1'b0
    };

    localparam t_acc_state ACC_RESET = '{
        mask: '0,
        low:  NO_RANGE,
        high: NO_RANGE,
        err:  1'b0
    };

    // Signed value of the number read so far
    function automatic logic signed [31:0] num_value(input logic [NUM_W-1:0] mag,
                                                     input logic             neg);
        logic signed [31:0] m;
        m = $signed({1'b0, mag});
        return neg ? -m : m;
    endfunction

endpackage

// ===== rtl/nltp_char_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nltp_char_step - token reader update for one non-space character
// Detects the ".." split and runs the atoi-style digit accumulator.
// ----------------------------------------------------------------------------
module nltp_char_step
    import nltp_pkg::*;
(
    input  logic [7:0] i_char,
    input  t_tok_state i_tok,
    output t_tok_state o_tok
);

    logic                 is_digit;
    logic                 is_ws;
    logic                 is_sign;
    logic                 is_dot;
    logic [34:0]          prod;
    logic [NUM_W-1:0]     num_sat;

    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_ws    = (i_char >= CH_TAB) && (i_char <= CH_CR);
    assign is_sign  = (i_char == CH_PLUS) || (i_char == CH_MINUS);
    assign is_dot   = (i_char == CH_DOT);

    // acc*10 + digit as shift-add, saturated to the 31-bit magnitude
    assign prod = ({4'd0, i_tok.num_acc} << 3) + ({4'd0, i_tok.num_acc} << 1)
                + {27'd0, i_char - CH_ZERO};
    assign num_sat = (prod > {4'd0, NUM_SAT}) ? NUM_SAT : prod[NUM_W-1:0];

    always_comb begin
        o_tok = i_tok;
        if (!i_tok.in_second && is_dot && i_tok.prev_dot) begin
            // second dot: latch left side and start the right side
            o_tok.first_val = num_value(i_tok.num_acc, i_tok.neg);
            o_tok.in_second = 1'b1;
            o_tok.prev_dot  = 1'b0;
            o_tok.num_acc   = '0;
            o_tok.phase     = PH_SKIP;
            o_tok.neg       = 1'b0;
        end else begin
            if (!i_tok.in_second) begin
                o_tok.prev_dot = is_dot;
            end
            // number reader
            unique case (i_tok.phase)
                PH_DONE: begin
                end
                PH_SKIP: begin
                    if (is_digit) begin
                        o_tok.num_acc = num_sat;
                        o_tok.phase   = PH_DIGITS;
                    end else if (is_ws) begin
                    end else if (is_sign) begin
                        o_tok.neg   = (i_char == CH_MINUS);
                        o_tok.phase = PH_DIGITS;
                    end else begin
                        o_tok.phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        o_tok.num_acc = num_sat;
                    end else begin
                        o_tok.phase = PH_DONE;
                    end
                end
                default: begin
                    o_tok.phase = PH_DONE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/nltp_token_close.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nltp_token_close - applies a finished token to the accumulators
// Single values set a mask bit; "a..b" tokens set the one allowed range.
// ----------------------------------------------------------------------------
module nltp_token_close
    import nltp_pkg::*;
(
    input  t_tok_state i_tok,
    input  t_acc_state i_acc,
    output t_acc_state o_acc
);

    logic signed [31:0]   val;
    logic signed [31:0]   val_m1;
    logic [MASK_BITS-1:0] bit_sel;
    logic                 single_ok;
    logic                 range_ok;

    assign val       = num_value(i_tok.num_acc, i_tok.neg);
    assign val_m1    = val - 32'sd1;
    assign bit_sel   = {{(MASK_BITS-1){1'b0}}, 1'b1} << val_m1[MASK_IDX_W-1:0];
    assign single_ok = (val > 32'sd0) && (val <= 32'(MASK_BITS));
    assign range_ok  = (i_tok.first_val >= 32'sd0) && (val >= 32'sd0)
                    && (i_tok.first_val < val);

    always_comb begin
        o_acc = i_acc;
        if (i_tok.in_second) begin
            // range token: must be ordered and the first range
            if (!range_ok || (i_acc.high >= 32'sd0)) begin
                o_acc.err = 1'b1;
            end else begin
                o_acc.low  = i_tok.first_val;
                o_acc.high = val;
            end
        end else begin
            // single value: in range and not seen before
            if (!single_ok || ((i_acc.mask & bit_sel) != '0)) begin
                o_acc.err = 1'b1;
            end else begin
                o_acc.mask = i_acc.mask | bit_sel;
            end
        end
    end

endmodule

// ===== rtl/number_list_text_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_list_text_parser_top - number-list text parser
// Reads list text one character per transfer and reports mask, range and
// error flag after the last character.
//
//   channel | direction | handshake             | payload
//   in      | input     | i_in_valid/o_in_ready | t_in_item  (char, last flag)
//   out     | output    | o_out_valid/i_out_ready | t_out_item (mask, range, err)
//
// One character per cycle, except that a last character can stall: a transfer
// lands in the input register and is then taken to update the token and text
// state and, on the last character, to load the result register. Only a last
// character waits on a full result register; other characters keep flowing
// while a result is held. Synchronous active-low reset returns the parser to
// its empty-text state.
// ----------------------------------------------------------------------------
module number_list_text_parser_top
    import nltp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic       r_in_valid;
    t_in_item   r_in_data;
    t_tok_state r_tok;
    t_acc_state r_acc;
    logic       r_out_valid;
    t_out_item  r_out_data;

    t_tok_state tok_fed;
    t_tok_state tok_close_in;
    t_acc_state acc_closed;
    logic       is_space;
    logic       proc_fire;

    // Character update and token close
    nltp_char_step u_char_step (
        .i_char (r_in_data.char_byte),
        .i_tok  (r_tok),
        .o_tok  (tok_fed)
    );

    assign is_space     = (r_in_data.char_byte == CH_SPACE);
    assign tok_close_in = is_space ? r_tok : tok_fed;

    nltp_token_close u_token_close (
        .i_tok (tok_close_in),
        .i_acc (r_acc),
        .o_acc (acc_closed)
    );

    // Handshake: the last character needs room in the result register
    assign proc_fire  = r_in_valid && (!r_in_data.last_char || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc_fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= TOK_RESET;
            r_acc <= ACC_RESET;
        end else if (proc_fire) begin
            if (r_in_data.last_char) begin
                r_tok <= TOK_RESET;
                r_acc <= ACC_RESET;
            end else if (is_space) begin
                r_tok <= TOK_RESET;
                r_acc <= acc_closed;
            end else begin
                r_tok <= tok_fed;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && r_in_data.last_char) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // A trailing space leaves an empty token, which always flags an error
    always_ff @(posedge i_clk) begin
        if (proc_fire && r_in_data.last_char) begin
            r_out_data.member_mask <= acc_closed.mask;
            r_out_data.range_low   <= acc_closed.low;
            r_out_data.range_high  <= acc_closed.high;
            r_out_data.parse_error <= acc_closed.err | is_space;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== dv/tb_number_list_text_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_number_list_text_parser_top - self-checking bench for the list parser
// Feeds list texts one character per transfer, a short directed set first and
// then random texts built mostly from well-formed tokens. A local model of the
// parser predicts each summary, and every output transfer is checked field by
// field. Both sides idle at random; the receiver holds off once for a long
// stretch and the sender drains twice before carrying on.
// ----------------------------------------------------------------------------
module tb_number_list_text_parser_top;
    import nltp_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int CHAR_TARGET   = 700;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_TRIGGER  = 250;
    localparam int IDLE_PERCENT  = 25;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 10;

    // One character waiting to be sent; drain_first holds it back until every
    // summary already due has come out
    typedef struct {
        t_in_item item;
        bit       drain_first;
    } t_text_char;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    t_text_char text_chars[$];
    t_out_item  expected_summaries[$];
    logic [7:0] text_buf[$];

    int cycle_count     = 0;
    int chars_accepted  = 0;
    int summaries_seen  = 0;
    int texts_queued    = 0;
    int fail_count      = 0;
    int hold_left       = 0;
    bit hold_done       = 1'b0;

    // Parser model state
    logic [MASK_BITS-1:0] pr_mask;
    logic signed [31:0]   pr_low;
    logic signed [31:0]   pr_high;
    logic                 pr_err;
    logic [NUM_W-1:0]     pr_num;
    longint               pr_first;
    t_phase               pr_phase;
    logic                 pr_neg;
    logic                 pr_in_second;
    logic                 pr_prev_dot;

    number_list_text_parser_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic void clear_number_model();
        pr_num   = '0;
        pr_phase = PH_SKIP;
        pr_neg   = 1'b0;
    endfunction

    function automatic void reset_parser_model();
        pr_mask      = '0;
        pr_low       = NO_RANGE;
        pr_high      = NO_RANGE;
        pr_err       = 1'b0;
        pr_first     = 0;
        pr_in_second = 1'b0;
        pr_prev_dot  = 1'b0;
        clear_number_model();
    endfunction

    function automatic longint signed_number();
        return pr_neg ? -longint'(pr_num) : longint'(pr_num);
    endfunction

    // atoi-style reader: whitespace and sign only before the digits
    function automatic void read_digit_char(logic [7:0] c);
        longint acc;
        if (pr_phase == PH_DONE)
            return;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            acc = longint'(pr_num) * 10 + (longint'(c) - longint'(CH_ZERO));
            pr_num   = (acc > longint'(NUM_SAT)) ? NUM_SAT : acc[NUM_W-1:0];
            pr_phase = PH_DIGITS;
            return;
        end
        if (pr_phase == PH_SKIP) begin
            if (c >= CH_TAB && c <= CH_CR)
                return;
            if (c == CH_PLUS || c == CH_MINUS) begin
                pr_neg   = (c == CH_MINUS);
                pr_phase = PH_DIGITS;
                return;
            end
        end
        pr_phase = PH_DONE;
    endfunction

    // Token end: either a single member or a range
    function automatic void close_token();
        longint v;
        v = signed_number();
        if (pr_in_second) begin
            if (pr_first < 0 || v < 0 || pr_first >= v || pr_high >= 0) begin
                pr_err = 1'b1;
            end else begin
                pr_low  = pr_first[31:0];
                pr_high = v[31:0];
            end
        end else if (v <= 0 || v > MASK_BITS) begin
            pr_err = 1'b1;
        end else if (pr_mask[int'(v - 1)]) begin
            pr_err = 1'b1;
        end else begin
            pr_mask[int'(v - 1)] = 1'b1;
        end
        pr_first     = 0;
        pr_in_second = 1'b0;
        pr_prev_dot  = 1'b0;
        clear_number_model();
    endfunction

    function automatic void predict_char(t_in_item it);
        t_out_item summary;
        if (it.char_byte == CH_SPACE) begin
            close_token();
        end else if (!pr_in_second && it.char_byte == CH_DOT && pr_prev_dot) begin
            pr_first     = signed_number();
            pr_in_second = 1'b1;
            pr_prev_dot  = 1'b0;
            clear_number_model();
        end else begin
            if (!pr_in_second)
                pr_prev_dot = (it.char_byte == CH_DOT);
            read_digit_char(it.char_byte);
        end
        if (it.last_char) begin
            close_token();
            summary.member_mask = pr_mask[31:0];
            summary.range_low   = pr_low;
            summary.range_high  = pr_high;
            summary.parse_error = pr_err;
            expected_summaries.push_back(summary);
            reset_parser_model();
        end
    endfunction

    // ------------------------------------------------------------------
    // Text building
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b);
        text_buf.push_back(b);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic commit_text(input bit drain_first);
        t_text_char tc;
        foreach (text_buf[i]) begin
            tc.item.char_byte = text_buf[i];
            tc.item.last_char = (i == text_buf.size() - 1);
            tc.drain_first    = drain_first && (i == 0);
            text_chars.push_back(tc);
        end
        text_buf.delete();
        texts_queued++;
    endtask

    task automatic add_random_token();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            // plain member value, sometimes with a plus sign
            if ($urandom_range(0, 9) == 0)
                add_byte(CH_PLUS);
            add_str($sformatf("%0d", $urandom_range(1, MASK_BITS)));
        end else if (kind < 65) begin
            add_str($sformatf("%0d..%0d", $urandom_range(0, 40), $urandom_range(0, 80)));
        end else if (kind < 72) begin
            // long digit string, may saturate
            if ($urandom_range(0, 1))
                add_byte(CH_MINUS);
            repeat ($urandom_range(9, 14))
                add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end else if (kind < 80) begin
            repeat ($urandom_range(1, 4))
                add_byte(8'($urandom_range(0, 255)));
        end else if (kind < 85) begin
            // empty token: nothing between separators
        end else if (kind < 92) begin
            repeat ($urandom_range(1, 2))
                add_byte(8'($urandom_range(CH_TAB, CH_CR)));
            if ($urandom_range(0, 2) == 0)
                add_byte(CH_MINUS);
            add_str($sformatf("%0d", $urandom_range(0, 40)));
            if ($urandom_range(0, 1))
                add_byte(8'($urandom_range(0, 255)));
        end else begin
            case ($urandom_range(0, 4))
                0: add_str($sformatf("..%0d", $urandom_range(0, 40)));
                1: add_str($sformatf("%0d..", $urandom_range(0, 40)));
                2: add_str($sformatf("%0d...%0d", $urandom_range(0, 9), $urandom_range(0, 40)));
                3: add_str($sformatf("%0d..-%0d", $urandom_range(0, 9), $urandom_range(0, 40)));
                default: add_str($sformatf("-%0d..%0d", $urandom_range(0, 9),
                                           $urandom_range(0, 40)));
            endcase
        end
    endtask

    task automatic log_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int ntok;
        reset_parser_model();

        // members at both ends, duplicate, empty token, reversed range
        add_str("32 1 1  3..2");
        commit_text(1'b0);
        // range upper side saturates
        add_str("0..9999999999");
        commit_text(1'b0);
        // whitespace skip, plus sign, NUL ends a number, minus, trailing CR
        add_byte(CH_TAB);
        add_str("+7");
        add_byte(8'h00);
        add_str("x -3");
        add_byte(CH_CR);
        commit_text(1'b0);
        // lone all-ones byte as the whole text
        add_byte(8'hFF);
        commit_text(1'b0);

        // random texts; drain before the first and once in the middle
        while (text_chars.size() < CHAR_TARGET) begin
            ntok = $urandom_range(1, 8);
            for (int t = 0; t < ntok; t++) begin
                if (t != 0)
                    add_byte(CH_SPACE);
                add_random_token();
            end
            if (text_buf.size() == 0)
                add_byte(8'($urandom_range(0, 255)));
            commit_text(texts_queued == 4 || texts_queued == 40);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_chars.size() != 0 || i_in_valid || expected_summaries.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d texts, %0d characters, %0d summaries checked, %0d mismatches.",
                 texts_queued, chars_accepted, summaries_seen, fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Cycle counter and run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: run limit of %0d cycles reached, %0d summaries outstanding",
                     CYCLE_LIMIT, expected_summaries.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit         fire;
        bit         offer;
        t_text_char nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
        end else begin
            fire = i_in_valid && o_in_ready;
            if (fire) begin
                predict_char(i_in_data);
                chars_accepted++;
            end
            if (i_in_valid && !fire) begin
                // transfer still pending: hold valid and payload
            end else begin
                offer = (text_chars.size() != 0);
                if (offer && text_chars[0].drain_first && expected_summaries.size() != 0)
                    offer = 1'b0;
                if (offer && !(chars_accepted >= 450 && chars_accepted < 600))
                    offer = ($urandom_range(0, 99) >= IDLE_PERCENT);
                if (offer) begin
                    nxt = text_chars.pop_front();
                    i_in_data <= nxt.item;
                end
                i_in_valid <= offer;
            end
        end
    end

    // Long receiver hold-off, once, part way through the run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && chars_accepted >= HOLD_TRIGGER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Output monitor and checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        bit        no_stall;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                summaries_seen++;
                if (expected_summaries.size() == 0) begin
                    log_failure($sformatf("summary with none expected: mask=%h lo=%0d hi=%0d err=%b",
                                          o_out_data.member_mask, o_out_data.range_low,
                                          o_out_data.range_high, o_out_data.parse_error));
                end else begin
                    want = expected_summaries.pop_front();
                    if (o_out_data.member_mask !== want.member_mask ||
                        o_out_data.range_low   !== want.range_low   ||
                        o_out_data.range_high  !== want.range_high  ||
                        o_out_data.parse_error !== want.parse_error)
                        log_failure($sformatf({"summary %0d: mask exp %h got %h, lo exp %0d got %0d,",
                                               " hi exp %0d got %0d, err exp %b got %b"},
                                              summaries_seen, want.member_mask,
                                              o_out_data.member_mask, want.range_low,
                                              o_out_data.range_low, want.range_high,
                                              o_out_data.range_high, want.parse_error,
                                              o_out_data.parse_error));
                end
            end
            no_stall    = (summaries_seen >= 30 && summaries_seen < 45);
            i_out_ready <= (hold_left == 0) &&
                           (no_stall || $urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

endmodule
